// ===== design/ihdp_pkg.sv =====
// Package for the image header dimension probe: byte and result word types,
// format and status codes, signature tables and signature helper functions.
// Depends on nothing.
package ihdp_pkg;

    // Format codes
    typedef enum logic [2:0] {
        FMT_PNG  = 3'd0,
        FMT_GIF  = 3'd1,
        FMT_BMP  = 3'd2,
        FMT_JPEG = 3'd3,
        FMT_NONE = 3'd4
    } t_format;

    // Status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte;

    // One result word
    typedef struct packed {
        t_status     status;
        t_format     image_format;
        logic [30:0] width;
        logic [30:0] height;
    } t_result;

    // Registered input word as seen by the parser
    typedef struct packed {
        logic  valid;
        t_byte item;
    } t_byte_stage;

    // Result word offered by the parser
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_emit;

    // JPEG marker bytes
    localparam logic [7:0] JPG_PREFIX  = 8'hFF;
    localparam logic [7:0] JPG_SOI     = 8'hD8;
    localparam logic [7:0] JPG_SOS     = 8'hDA;
    localparam logic [7:0] JPG_SOF_LO  = 8'hC0;
    localparam logic [7:0] JPG_SOF_HI  = 8'hCF;
    localparam logic [7:0] JPG_DHT     = 8'hC4;
    localparam logic [7:0] JPG_JPG     = 8'hC8;
    localparam logic [7:0] JPG_DAC     = 8'hCC;
    localparam logic [7:0] JPG_TEM     = 8'h01;
    localparam logic [7:0] JPG_RST0    = 8'hD0;
    localparam logic [7:0] JPG_EOI     = 8'hD9;

    // Leading bytes of each format
    localparam logic [7:0] LEAD_PNG = 8'h89;
    localparam logic [7:0] LEAD_GIF = 8'h47;
    localparam logic [7:0] LEAD_BMP = 8'h42;
    localparam logic [7:0] BMP_SECOND = 8'h4D;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] GIF_SIG [6] = '{8'h47, 8'h49, 8'h46, 8'h38,
                                           8'h37, 8'h61};
    localparam logic [7:0] GIF_VER_89 = 8'h39;

    // Signature length in bytes for a format
    function automatic logic [3:0] sig_length(input t_format fmt);
        case (fmt)
            FMT_PNG:  sig_length = 4'd8;
            FMT_GIF:  sig_length = 4'd6;
            FMT_BMP:  sig_length = 4'd2;
            FMT_JPEG: sig_length = 4'd2;
            default:  sig_length = 4'd0;
        endcase
    endfunction

    // Check one signature byte at a position inside the signature
    function automatic logic sig_match(input t_format fmt, input logic [15:0] p,
                                       input logic [7:0] d);
        logic ok;
        ok = 1'b0;
        case (fmt)
            FMT_PNG:  ok = (p < 16'd8) && (d == PNG_SIG[p[2:0]]);
            FMT_GIF: begin
                if (p == 16'd4) begin
                    ok = (d == GIF_SIG[4]) || (d == GIF_VER_89);
                end else begin
                    ok = (p < 16'd6) && (d == GIF_SIG[p[2:0]]);
                end
            end
            FMT_BMP:  ok = (p == 16'd1) && (d == BMP_SECOND);
            FMT_JPEG: ok = (p == 16'd1) && (d == JPG_SOI);
            default:  ok = 1'b0;
        endcase
        sig_match = ok;
    endfunction

endpackage

// ===== design/ihdp_stream_if.sv =====
// Valid/ready stream channel carrying one word of type T per handshake.
// Depends on nothing; the payload type is chosen where it is instantiated.
interface ihdp_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/ihdp_in_stage.sv =====
// Input register of the probe: takes byte words from the stream channel.
// Depends on ihdp_pkg and ihdp_stream_if.
module ihdp_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ihdp_stream_if.sink          i_byte,
    input  logic                 i_adv,
    output ihdp_pkg::t_byte_stage o_stage
);
    import ihdp_pkg::*;

    logic  r_valid;
    t_byte r_item;

    // Take a word when empty or when the held word moves on
    assign i_byte.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_item <= i_byte.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;
endmodule

// ===== design/ihdp_parser.sv =====
// Per-file parser: signature check, fixed-offset header fields and JPEG
// marker walk, one byte per cycle while the result stage is not stalled. Depends on ihdp_pkg.
module ihdp_parser #(
    parameter int PROBE_LIMIT = 32768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ihdp_pkg::t_byte_stage i_stage,
    input  logic                  i_adv,
    output ihdp_pkg::t_emit       o_emit
);
    import ihdp_pkg::*;

    localparam int PosW = $clog2(PROBE_LIMIT + 1);

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_FILL   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_SKIP   = 3'd4,
        PH_SOF    = 3'd5
    } t_phase;

    logic [PosW-1:0] r_pos,   n_pos;
    t_format         r_fmt,   n_fmt;
    t_phase          r_phase, n_phase;
    logic [15:0]     r_seg,   n_seg;
    logic [7:0]      r_len_hi, n_len_hi;
    logic [2:0]      r_fo,    n_fo;
    logic [31:0]     r_w,     n_w;
    logic [31:0]     r_h,     n_h;
    logic            r_sent,  n_sent;

    logic            em;
    t_status         em_st;
    t_format         em_fmt;
    logic [31:0]     em_w, em_h;

    logic [15:0]     p;
    logic [PosW:0]   pos_inc;
    logic [7:0]      d;
    logic            take;
    logic [1:0]      lane;
    logic [31:0]     h_abs;
    logic [15:0]     seg_len;

    assign d       = i_stage.item.data_byte;
    assign p       = 16'(r_pos);
    assign pos_inc = {1'b0, r_pos} + 1'b1;
    assign take    = i_stage.valid && i_adv;

    // Work out the next state and any result for the held byte
    always_comb begin
        n_pos    = r_pos;
        n_fmt    = r_fmt;
        n_phase  = r_phase;
        n_seg    = r_seg;
        n_len_hi = r_len_hi;
        n_fo     = r_fo;
        n_w      = r_w;
        n_h      = r_h;
        n_sent   = r_sent;
        em       = 1'b0;
        em_st    = ST_UNKNOWN;
        em_fmt   = FMT_NONE;
        em_w     = '0;
        em_h     = '0;
        lane     = '0;
        h_abs    = '0;
        seg_len  = {r_len_hi, d};

        if (i_stage.valid && !r_sent && (pos_inc <= (PosW+1)'(PROBE_LIMIT))) begin
            if (p == 16'd0) begin
                // Pick the candidate format from the leading byte
                case (d)
                    LEAD_PNG:   n_fmt = FMT_PNG;
                    LEAD_GIF:   n_fmt = FMT_GIF;
                    LEAD_BMP:   n_fmt = FMT_BMP;
                    JPG_PREFIX: n_fmt = FMT_JPEG;
                    default:    em = 1'b1;
                endcase
            end else if (p < 16'(sig_length(r_fmt))) begin
                // Drop out on the first signature mismatch
                if (!sig_match(r_fmt, p, d)) begin
                    em = 1'b1;
                end
            end else begin
                case (r_fmt)
                    FMT_PNG: begin
                        if (p >= 16'd16 && p <= 16'd19) begin
                            n_w = {r_w[23:0], d};
                        end else if (p >= 16'd20 && p <= 16'd23) begin
                            n_h = {r_h[23:0], d};
                        end
                        if (p == 16'd23) begin
                            em     = 1'b1;
                            em_fmt = FMT_PNG;
                            if (n_w == '0 || n_w[31] || n_h == '0 || n_h[31]) begin
                                em_st = ST_MALFORMED;
                            end else begin
                                em_st = ST_FOUND;
                                em_w  = n_w;
                                em_h  = n_h;
                            end
                        end
                    end
                    FMT_GIF: begin
                        // Little-endian 16-bit fields
                        if (p == 16'd6) begin
                            n_w = r_w | {24'd0, d};
                        end else if (p == 16'd7) begin
                            n_w = r_w | {16'd0, d, 8'd0};
                        end else if (p == 16'd8) begin
                            n_h = r_h | {24'd0, d};
                        end else if (p == 16'd9) begin
                            n_h = r_h | {16'd0, d, 8'd0};
                        end
                        if (p == 16'd9) begin
                            em     = 1'b1;
                            em_fmt = FMT_GIF;
                            if (n_w == '0 || n_h == '0) begin
                                em_st = ST_MALFORMED;
                            end else begin
                                em_st = ST_FOUND;
                                em_w  = n_w;
                                em_h  = n_h;
                            end
                        end
                    end
                    FMT_BMP: begin
                        // Little-endian 32-bit fields, byte lane from the offset
                        if (p >= 16'd18 && p <= 16'd21) begin
                            lane = 2'(p - 16'd18);
                            n_w  = r_w | (32'(d) << {lane, 3'b000});
                        end else if (p >= 16'd22 && p <= 16'd25) begin
                            lane = 2'(p - 16'd22);
                            n_h  = r_h | (32'(d) << {lane, 3'b000});
                        end
                        h_abs = n_h[31] ? (32'd0 - n_h) : n_h;
                        if (p == 16'd25) begin
                            em     = 1'b1;
                            em_fmt = FMT_BMP;
                            if (n_h == 32'h8000_0000 || h_abs == '0 || n_w == '0
                                    || n_w[31]) begin
                                em_st = ST_MALFORMED;
                            end else begin
                                em_st = ST_FOUND;
                                em_w  = n_w;
                                em_h  = h_abs;
                            end
                        end
                    end
                    FMT_JPEG: begin
                        case (r_phase)
                            PH_PREFIX: begin
                                if (d != JPG_PREFIX) begin
                                    em     = 1'b1;
                                    em_st  = ST_MALFORMED;
                                    em_fmt = FMT_JPEG;
                                end else begin
                                    n_phase = PH_FILL;
                                end
                            end
                            PH_FILL: begin
                                // Skip fill bytes, then classify the marker
                                if (d == JPG_PREFIX) begin
                                    n_phase = PH_FILL;
                                end else if ((d inside {[JPG_SOF_LO:JPG_SOF_HI]})
                                        && !(d inside {JPG_DHT, JPG_JPG, JPG_DAC})) begin
                                    n_phase = PH_SOF;
                                    n_fo    = '0;
                                    n_w     = '0;
                                    n_h     = '0;
                                end else if (d inside {JPG_TEM, [JPG_RST0:JPG_EOI]}) begin
                                    n_phase = PH_PREFIX;
                                end else if (d == JPG_SOS) begin
                                    em     = 1'b1;
                                    em_st  = ST_MALFORMED;
                                    em_fmt = FMT_JPEG;
                                end else begin
                                    n_phase = PH_LEN_HI;
                                end
                            end
                            PH_LEN_HI: begin
                                n_len_hi = d;
                                n_phase  = PH_LEN_LO;
                            end
                            PH_LEN_LO: begin
                                if (seg_len < 16'd2) begin
                                    em     = 1'b1;
                                    em_st  = ST_MALFORMED;
                                    em_fmt = FMT_JPEG;
                                end else begin
                                    n_seg   = seg_len - 16'd2;
                                    n_phase = (seg_len == 16'd2) ? PH_PREFIX : PH_SKIP;
                                end
                            end
                            PH_SKIP: begin
                                n_seg = r_seg - 16'd1;
                                if (r_seg == 16'd1) begin
                                    n_phase = PH_PREFIX;
                                end
                            end
                            PH_SOF: begin
                                // Frame header: height at offsets 3-4, width at 5-6
                                if (r_fo == 3'd3 || r_fo == 3'd4) begin
                                    n_h = {16'd0, r_h[7:0], d};
                                end else if (r_fo == 3'd5 || r_fo == 3'd6) begin
                                    n_w = {16'd0, r_w[7:0], d};
                                end
                                if (r_fo >= 3'd6) begin
                                    em     = 1'b1;
                                    em_fmt = FMT_JPEG;
                                    if (n_w == '0 || n_h == '0) begin
                                        em_st = ST_MALFORMED;
                                    end else begin
                                        em_st = ST_FOUND;
                                        em_w  = n_w;
                                        em_h  = n_h;
                                    end
                                end else begin
                                    n_fo = r_fo + 3'd1;
                                end
                            end
                            default: begin
                                em     = 1'b1;
                                em_st  = ST_MALFORMED;
                                em_fmt = FMT_JPEG;
                            end
                        endcase
                    end
                    default: em = 1'b1;
                endcase
            end

            n_pos = PosW'(pos_inc);

            // Close out at the last byte or at the probe limit
            if (!em && (i_stage.item.last_byte || pos_inc >= (PosW+1)'(PROBE_LIMIT))) begin
                em = 1'b1;
                if ((pos_inc < (PosW+1)'(sig_length(n_fmt))) || n_fmt == FMT_NONE) begin
                    em_st  = ST_UNKNOWN;
                    em_fmt = FMT_NONE;
                end else begin
                    em_st  = ST_MALFORMED;
                    em_fmt = n_fmt;
                end
            end
            n_sent = em;
        end

        // Start over after the last byte of a file
        if (i_stage.valid && i_stage.item.last_byte) begin
            n_pos    = '0;
            n_fmt    = FMT_NONE;
            n_phase  = PH_PREFIX;
            n_seg    = '0;
            n_len_hi = '0;
            n_fo     = '0;
            n_w      = '0;
            n_h      = '0;
            n_sent   = 1'b0;
        end
    end

    // Hold parser state; advance when the byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fmt    <= FMT_NONE;
            r_phase  <= PH_PREFIX;
            r_seg    <= '0;
            r_len_hi <= '0;
            r_fo     <= '0;
            r_w      <= '0;
            r_h      <= '0;
            r_sent   <= 1'b0;
        end else if (take) begin
            r_pos    <= n_pos;
            r_fmt    <= n_fmt;
            r_phase  <= n_phase;
            r_seg    <= n_seg;
            r_len_hi <= n_len_hi;
            r_fo     <= n_fo;
            r_w      <= n_w;
            r_h      <= n_h;
            r_sent   <= n_sent;
        end
    end

    // Dimensions are zero unless found
    assign o_emit.valid            = em;
    assign o_emit.res.status       = em_st;
    assign o_emit.res.image_format = em_fmt;
    assign o_emit.res.width        = (em_st == ST_FOUND) ? em_w[30:0] : 31'd0;
    assign o_emit.res.height       = (em_st == ST_FOUND) ? em_h[30:0] : 31'd0;
endmodule

// ===== design/ihdp_out_stage.sv =====
// Result register of the probe: holds one result word for the stream channel.
// Depends on ihdp_pkg and ihdp_stream_if.
module ihdp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ihdp_pkg::t_emit i_emit,
    ihdp_stream_if.source   o_result,
    output logic            o_adv
);
    import ihdp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Move on when the register is empty or its word is taken
    assign o_adv = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_emit.valid;
        end
        if (o_adv) begin
            r_res <= i_emit.res;
        end
    end

    assign o_result.valid = r_valid;
    assign o_result.data  = r_res;
endmodule

// ===== design/image_header_dimension_probe.sv =====
// Image header dimension probe: one file byte per cycle in while the output is not
// stalled, one result word per file out. The byte that decides a result passes the
// input register; the result register then holds and offers the result word.
// Reset (synchronous, active low) empties both registers and rewinds the parser.
// Bytes at or past PROBE_LIMIT are ignored up to the last-byte mark.
module image_header_dimension_probe #(
    parameter int PROBE_LIMIT = 32768
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihdp_stream_if.sink   i_byte,
    ihdp_stream_if.source o_result
);
    import ihdp_pkg::*;

    t_byte_stage stage;
    t_emit       emit_w;
    logic        adv;

    ihdp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_adv   (adv),
        .o_stage (stage)
    );

    ihdp_parser #(.PROBE_LIMIT(PROBE_LIMIT)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .i_adv   (adv),
        .o_emit  (emit_w)
    );

    ihdp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit_w),
        .o_result (o_result),
        .o_adv    (adv)
    );

`ifndef ASSERT_OFF
    // Unrecognized files carry no format
    a_unknown_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status == ST_UNKNOWN)
            |-> (o_result.data.image_format == FMT_NONE))
        else $error("unknown status with a format");

    // Dimensions only with a found status
    a_dims_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.status != ST_FOUND)
            |-> (o_result.data.width == '0 && o_result.data.height == '0))
        else $error("dimensions without found status");

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");
`endif
endmodule
